// ----- src/usel_pkg.sv -----
// Shared types and constants for the upstream endpoint selector.
package usel_pkg;

  localparam int MaxEnd = 16;
  localparam int IdxW   = $clog2(MaxEnd);
  localparam int CntW   = IdxW + 1;

  localparam logic [7:0]  DefFailLimit = 8'd3;
  localparam logic [31:0] DefCooldown  = 32'd5000;

  localparam logic [2:0] KindSelect = 3'd0;
  localparam logic [2:0] KindSticky = 3'd1;
  localparam logic [2:0] KindResult = 3'd2;
  localparam logic [2:0] KindBegin  = 3'd3;
  localparam logic [2:0] KindEnd    = 3'd4;
  localparam logic [2:0] KindAdd    = 3'd5;

  localparam logic [1:0] CfgFailLimit = 2'd0;
  localparam logic [1:0] CfgCooldown  = 2'd1;
  localparam logic [1:0] CfgPickMode  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BAD  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0]        weight;
    logic signed [21:0] rw;
    logic               healthy;
    logic [7:0]         fails;
    logic [63:0]        retry;
    logic [15:0]        inflight;
  } entry_t;

endpackage

// ----- src/usel_ram.sv -----
// Endpoint table memory: one write port, one read port with registered data.
module usel_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [usel_pkg::IdxW-1:0] waddr,
  input  usel_pkg::entry_t          wdata,
  input  logic [usel_pkg::IdxW-1:0] raddr,
  output usel_pkg::entry_t          rdata
);
  import usel_pkg::*;

  entry_t mem [MaxEnd];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/upstream_endpoint_selector_unit.sv -----
// Top level of the upstream endpoint selector: control sequencer around the table memory.
//
//  channel | signals                                              | dir
//  in      | in_valid, in_stall, kind, now_time, slot_index, ...  | in
//  out     | out_valid, out_stall, status, chosen_index           | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data            | in
//
// One item at a time; a new item is accepted only in the idle state. Add, undefined
// kinds and rejected items go straight to the result; result/begin/end read the table,
// then write back. A select scans the table one entry per cycle through the single read
// port. In round robin mode the winner is written back afterwards; a sticky select
// with a valid slot checks that slot first and scans only on a miss.
// Synchronous reset empties the table; the memory needs no clearing pass.
// A stalled result holds in the output register; the next item runs up to its own
// result and waits there.
module upstream_endpoint_selector_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] now_time,
  input  logic [3:0]  slot_index,
  input  logic        slot_valid,
  input  logic        succeeded,
  input  logic [15:0] new_weight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  chosen_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import usel_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_STICKY, S_SCAN, S_FINAL, S_UPD, S_DONE
  } state_t;

  state_t state;

  logic [7:0]  fail_limit;
  logic [31:0] cooldown_time;
  logic        pick_mode;

  logic [CntW-1:0] count;
  logic [2:0]      k;
  logic [63:0]     now;
  logic [IdxW-1:0] idx;
  logic            sv;
  logic            ok;
  logic [15:0]     w;

  logic [CntW-1:0] iss;
  logic            pend;
  logic [IdxW-1:0] pend_idx;
  logic            have;
  logic [IdxW-1:0] best_idx;
  entry_t          best;
  logic [20:0]     total;

  status_t         res_status;
  logic [IdxW-1:0] res_index;

  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  logic [IdxW-1:0] raddr;
  entry_t          rd;

  usel_ram u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd)
  );

  // Datapath on the entry just read
  logic               avail;
  logic [22:0]        rw_sum;
  logic signed [21:0] rw_inc;
  logic               better;
  logic [22:0]        rw_diff;
  logic signed [21:0] rw_dec;
  logic [7:0]         lim;
  logic [31:0]        cd;
  logic [7:0]         fails_inc;
  logic [64:0]        retry_sum;
  logic [63:0]        retry_new;
  entry_t             upd;
  entry_t             scan_ent;
  entry_t             add_ent;
  entry_t             fin_ent;

  always_comb begin
    avail  = rd.healthy || (now >= rd.retry);
    rw_sum = {rd.rw[21], rd.rw} + {7'd0, rd.weight};
    if (rw_sum[22] != rw_sum[21]) begin
      rw_inc = rw_sum[22] ? 22'sh200000 : 22'sh1FFFFF;
    end else begin
      rw_inc = rw_sum[21:0];
    end
    scan_ent    = rd;
    scan_ent.rw = rw_inc;
    if (!have) begin
      better = 1'b1;
    end else if (pick_mode) begin
      better = rd.inflight < best.inflight;
    end else begin
      better = rw_inc > best.rw;
    end

    rw_diff = {best.rw[21], best.rw} - {2'd0, total};
    if (rw_diff[22] != rw_diff[21]) begin
      rw_dec = rw_diff[22] ? 22'sh200000 : 22'sh1FFFFF;
    end else begin
      rw_dec = rw_diff[21:0];
    end
    fin_ent    = best;
    fin_ent.rw = rw_dec;

    lim       = (fail_limit == 8'd0) ? DefFailLimit : fail_limit;
    cd        = (cooldown_time == 32'd0) ? DefCooldown : cooldown_time;
    fails_inc = (rd.fails == 8'hFF) ? rd.fails : rd.fails + 8'd1;
    retry_sum = {1'b0, now} + {33'd0, cd};
    retry_new = retry_sum[64] ? {64{1'b1}} : retry_sum[63:0];
    upd = rd;
    case (k)
      KindResult: begin
        if (ok) begin
          upd.fails   = 8'd0;
          upd.healthy = 1'b1;
          upd.retry   = 64'd0;
        end else begin
          upd.fails = fails_inc;
          if (fails_inc >= lim) begin
            upd.healthy = 1'b0;
            upd.retry   = retry_new;
          end
        end
      end
      KindBegin: begin
        if (rd.inflight != 16'hFFFF) upd.inflight = rd.inflight + 16'd1;
      end
      KindEnd: begin
        if (rd.inflight != 16'd0) upd.inflight = rd.inflight - 16'd1;
      end
      default: upd = rd;
    endcase

    add_ent          = '0;
    add_ent.weight   = (w == 16'd0) ? 16'd1 : w;
    add_ent.healthy  = 1'b1;
  end

  // Memory port steering
  always_comb begin
    raddr = (state == S_DECODE) ? idx : iss[IdxW-1:0];
    we    = 1'b0;
    waddr = pend_idx;
    wdata = scan_ent;
    case (state)
      S_DECODE: begin
        waddr = count[IdxW-1:0];
        wdata = add_ent;
        we    = (k == KindAdd) && (count < CntW'(MaxEnd));
      end
      S_SCAN: begin
        we = pend && avail && !pick_mode;
      end
      S_FINAL: begin
        we    = 1'b1;
        waddr = best_idx;
        wdata = fin_ent;
      end
      S_UPD: begin
        we    = 1'b1;
        waddr = idx;
        wdata = upd;
      end
      default: we = 1'b0;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fail_limit    <= DefFailLimit;
      cooldown_time <= DefCooldown;
      pick_mode     <= 1'b0;
      count         <= '0;
      out_valid     <= 1'b0;
      pend          <= 1'b0;
      have          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CfgFailLimit: fail_limit    <= cfg_data[7:0];
          CfgCooldown:  cooldown_time <= cfg_data;
          CfgPickMode:  pick_mode     <= cfg_data[0];
          default:      ;
        endcase
      end
      // drop the beat once taken, unless a new result replaces it
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            k     <= kind;
            now   <= now_time;
            idx   <= slot_index;
            sv    <= slot_valid;
            ok    <= succeeded;
            w     <= new_weight;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_status <= ST_OK;
          res_index  <= '0;
          iss        <= '0;
          pend       <= 1'b0;
          have       <= 1'b0;
          total      <= '0;
          state      <= S_DONE;
          case (k)
            KindSelect, KindSticky: begin
              if (count == '0) begin
                res_status <= ST_NONE;
              end else if (k == KindSticky && sv && {1'b0, idx} < count) begin
                state <= S_STICKY;
              end else begin
                state <= S_SCAN;
              end
            end
            KindResult, KindBegin, KindEnd: begin
              if ({1'b0, idx} >= count) begin
                res_status <= ST_BAD;
              end else begin
                state <= S_UPD;
              end
            end
            KindAdd: begin
              if (count >= CntW'(MaxEnd)) begin
                res_status <= ST_FULL;
              end else begin
                res_index <= count[IdxW-1:0];
                count     <= count + 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_STICKY: begin
          if (avail) begin
            res_index <= idx;
            state     <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue next read while the previous entry is evaluated
          if (iss < count) begin
            pend     <= 1'b1;
            pend_idx <= iss[IdxW-1:0];
            iss      <= iss + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && avail) begin
            total <= total + {5'd0, rd.weight};
            if (better) begin
              have     <= 1'b1;
              best_idx <= pend_idx;
              best     <= scan_ent;
            end
          end
          if (!pend && iss == count) begin
            if (!have) begin
              res_status <= ST_NONE;
              state      <= S_DONE;
            end else begin
              res_index <= best_idx;
              state     <= pick_mode ? S_DONE : S_FINAL;
            end
          end
        end
        S_FINAL: state <= S_DONE;
        S_UPD: begin
          res_index <= idx;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            chosen_index <= res_index;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxEnd))
    else $error("endpoint count beyond table size");

  a_chosen_in_table: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && chosen_index != 4'd0 |-> {1'b0, chosen_index} < count)
    else $error("chosen index outside table");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !we)
    else $error("table write outside an item");

endmodule
